// File: src/pfba_pkg.sv
package pfba_pkg;

	localparam int WORD_BITS = 32;
	localparam int WORD_IDX_W = 5;

	typedef enum logic [1:0] {
		MODE_ALLOC_ONE = 2'd0,
		MODE_ALLOC_RUN = 2'd1,
		MODE_FREE      = 2'd2,
		MODE_NONE      = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_DONE      = 2'd0,
		ST_NO_SPACE  = 2'd1,
		ST_RANGE     = 2'd2,
		ST_NOT_ALLOC = 2'd3
	} status_t;

	// Lowest clear bit of a word; bit 5 set when the word is full
	function automatic logic [5:0] first_zero(input logic [31:0] w);
		logic [5:0] r;
		r = 6'd32;
		for (int b = 31; b >= 0; b--) begin
			if (!w[b]) r = 6'(b);
		end
		return r;
	endfunction

endpackage

// File: src/pfba_map_ram.sv
module pfba_map_ram #(
	parameter int DEPTH = 128,
	parameter int AW = 7
) (
	input  logic        clk,
	input  logic        we,
	input  logic [AW-1:0] waddr,
	input  logic [31:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [31:0] rdata
);

	logic [31:0] mem [DEPTH];

	// One write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

// File: src/page_frame_bitmap_allocator.sv
// Channel | direction | handshake       | payload
// in      | into      | in_valid/in_stall | mode, count, frame
// out     | out of    | out_valid/out_stall | status, first_frame
// cfg     | into      | cfg_valid/cfg_ready | cfg_data (map_words_in_use)
// After reset the map is cleared by a pass over all DEPTH words (128 by default),
// during which no request beat is taken; configuration is taken at once.
// Allocation: each map word scanned is read, then the registered word is
// examined. One frame is then set in its word; a run spans up to three words,
// each read and then written.
// Free: the frame's word is read and examined, and the frame is cleared if it
// was allocated, before the result beat. A request refused at once goes straight
// to the result beat without a map read. A stalled result holds; the next
// request is taken once it has been delivered and the block is idle again.
module page_frame_bitmap_allocator #(
	parameter int TOTAL_FRAMES = 4096,
	parameter int MAX_RUN = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  mode,
	input  logic [6:0]  count,
	input  logic [11:0] frame,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [11:0] first_frame,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data
);

	localparam int DEPTH = TOTAL_FRAMES / pfba_pkg::WORD_BITS;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = AW + 1;
	localparam int FW = AW + pfba_pkg::WORD_IDX_W;

	typedef enum logic [6:0] {
		S_CLEAR = 7'b0000001,
		S_IDLE  = 7'b0000010,
		S_READ  = 7'b0000100,
		S_EXAM  = 7'b0001000,
		S_SETRD = 7'b0010000,
		S_SETWR = 7'b0100000,
		S_OUT   = 7'b1000000
	} state_t;

	state_t st_q;
	logic [7:0] words_q;
	logic [CW-1:0] limw;         // saturated word count
	logic [AW-1:0] addr_q;
	logic [CW-1:0] widx_q;       // word index being scanned
	logic [1:0] mode_q;
	logic [6:0] count_q;
	logic [11:0] frame_q;
	logic [6:0] run_q;           // free frames ending at previous word's end
	logic [FW:0] setf_q;         // next frame to set
	logic [FW:0] endf_q;         // last frame to set
	logic [1:0] status_q;
	logic [11:0] first_q;
	logic out_valid_q;

	logic we;
	logic [AW-1:0] waddr, raddr;
	logic [31:0] wdata, rdata;

	pfba_map_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	assign cfg_ready = 1'b1;
	assign in_stall = (st_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign status = status_q;
	assign first_frame = first_q;

	// Saturate register to map size
	always_comb begin
		if ({24'd0, words_q} > DEPTH) limw = CW'(DEPTH);
		else limw = CW'(words_q);
	end

	// Run search inside one word: a bit ends the run when the count_q frames
	// up to it are all free, looking back into the run carried from earlier
	// words; all bits are checked side by side
	logic        hit;
	logic [5:0]  hit_bit;
	logic [6:0]  run_nx;
	logic [5:0]  fz;
	logic [95:0] free_v;
	logic [63:0] tmask;
	logic [31:0] hit_v;
	logic [4:0]  hi_used;
	always_comb begin
		free_v = {~rdata, ~(64'hFFFF_FFFF_FFFF_FFFF >> run_q)};
		tmask = ~(64'hFFFF_FFFF_FFFF_FFFF >> count_q);
		for (int b = 0; b < 32; b++) begin
			hit_v[b] = ((free_v[64 + b -: 64] & tmask) == tmask);
		end
		hit = |hit_v;
		hit_bit = pfba_pkg::first_zero(~hit_v);
		// free run left at the top of the word, capped at 64 frames
		hi_used = '0;
		for (int b = 0; b < 32; b++) begin
			if (rdata[b]) hi_used = 5'(b);
		end
		if (rdata == '0) run_nx = (run_q >= 7'd32) ? 7'd64 : run_q + 7'd32;
		else run_nx = {2'b00, 5'd31 - hi_used};
		fz = pfba_pkg::first_zero(rdata);
	end

	logic [FW:0] wbase;
	assign wbase = {1'b0, widx_q[AW-1:0], 5'd0};

	logic [FW:0] run_start;
	assign run_start = (wbase | (FW+1)'(hit_bit)) + (FW+1)'(1) - (FW+1)'(count_q);

	// Bits of the current word that fall in [setf, endf]
	logic [31:0] set_mask;
	always_comb begin
		for (int b = 0; b < 32; b++) begin
			set_mask[b] = ((wbase | (FW+1)'(b)) >= setf_q) &&
				((wbase | (FW+1)'(b)) <= endf_q);
		end
	end

	always_comb begin
		raddr = addr_q;
		we = 1'b0;
		waddr = addr_q;
		wdata = '0;
		if (st_q == S_CLEAR) begin
			we = 1'b1;
		end else if (st_q == S_SETWR) begin
			we = 1'b1;
			wdata = rdata | set_mask;
		end else if (st_q == S_EXAM && mode_q == pfba_pkg::MODE_FREE) begin
			we = (status_q == pfba_pkg::ST_DONE) && rdata[frame_q[4:0]];
			wdata = rdata & ~(32'd1 << frame_q[4:0]);
		end
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) words_q <= 8'd128;
		else if (cfg_valid && cfg_ready) words_q <= cfg_data;
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_CLEAR;
			addr_q <= '0;
			out_valid_q <= 1'b0;
			widx_q <= '0;
			mode_q <= '0;
			count_q <= '0;
			frame_q <= '0;
			run_q <= '0;
			setf_q <= '0;
			endf_q <= '0;
			status_q <= pfba_pkg::ST_DONE;
			first_q <= '0;
		end else begin
			unique case (st_q)
				S_CLEAR: begin
					addr_q <= addr_q + AW'(1);
					if (addr_q == AW'(DEPTH - 1)) begin
						st_q <= S_IDLE;
						addr_q <= '0;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						mode_q <= mode;
						count_q <= count;
						frame_q <= frame;
						run_q <= '0;
						widx_q <= '0;
						addr_q <= '0;
						status_q <= pfba_pkg::ST_DONE;
						first_q <= '0;
						unique case (mode)
							pfba_pkg::MODE_ALLOC_ONE: begin
								if (limw == '0) begin
									status_q <= pfba_pkg::ST_NO_SPACE;
									st_q <= S_OUT;
								end else st_q <= S_READ;
							end
							pfba_pkg::MODE_ALLOC_RUN: begin
								if (limw == '0 || count == 7'd0 ||
									{25'd0, count} > MAX_RUN ||
									{{(32-CW-5){1'b0}}, limw, 5'd0} < {25'd0, count})
								begin
									status_q <= pfba_pkg::ST_NO_SPACE;
									st_q <= S_OUT;
								end else st_q <= S_READ;
							end
							pfba_pkg::MODE_FREE: begin
								if ({{(32-12){1'b0}}, frame} >=
									{{(32-CW-5){1'b0}}, limw, 5'd0}) begin
									status_q <= pfba_pkg::ST_RANGE;
									st_q <= S_OUT;
								end else begin
									addr_q <= AW'(frame >> pfba_pkg::WORD_IDX_W);
									st_q <= S_READ;
								end
							end
							default: st_q <= S_OUT;
						endcase
					end
				end
				S_READ: st_q <= S_EXAM;
				S_EXAM: begin
					if (mode_q == pfba_pkg::MODE_FREE) begin
						if (!rdata[frame_q[4:0]]) status_q <= pfba_pkg::ST_NOT_ALLOC;
						st_q <= S_OUT;
					end else if (mode_q == pfba_pkg::MODE_ALLOC_ONE && !fz[5]) begin
						setf_q <= wbase | (FW+1)'(fz[4:0]);
						endf_q <= wbase | (FW+1)'(fz[4:0]);
						first_q <= 12'(wbase | (FW+1)'(fz[4:0]));
						st_q <= S_SETWR;
					end else if (mode_q == pfba_pkg::MODE_ALLOC_RUN && hit) begin
						setf_q <= run_start;
						endf_q <= wbase | (FW+1)'(hit_bit);
						first_q <= 12'(run_start);
						addr_q <= AW'(run_start >> 5);
						widx_q <= CW'(run_start >> 5);
						st_q <= S_SETRD;
					end else if (widx_q + CW'(1) >= limw) begin
						status_q <= pfba_pkg::ST_NO_SPACE;
						st_q <= S_OUT;
					end else begin
						run_q <= run_nx;
						widx_q <= widx_q + CW'(1);
						addr_q <= addr_q + AW'(1);
						st_q <= S_READ;
					end
				end
				S_SETRD: st_q <= S_SETWR;
				S_SETWR: begin
					if ((wbase | (FW+1)'(31)) >= endf_q) st_q <= S_OUT;
					else begin
						widx_q <= widx_q + CW'(1);
						addr_q <= addr_q + AW'(1);
						st_q <= S_SETRD;
					end
				end
				S_OUT: begin
					if (!out_valid_q) out_valid_q <= 1'b1;
					else if (!out_stall) begin
						out_valid_q <= 1'b0;
						st_q <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	// A result is only offered from the output state
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> st_q == S_OUT) else $error("result outside output state");
	// No request taken during the clearing pass
	assert property (@(posedge clk) disable iff (!arst_n)
		st_q == S_CLEAR |-> in_stall) else $error("request during clear");
	// A free never writes a word while reporting failure
	assert property (@(posedge clk) disable iff (!arst_n)
		(we && st_q == S_EXAM) |-> status_q == pfba_pkg::ST_DONE)
		else $error("write on failed free");

endmodule
